[sv/rcfb_pkg.sv]
// Shared action codes and cell control type for the packet buffer allocator.
package rcfb_pkg;

   localparam logic [2:0] ACT_ALLOC    = 3'd0;
   localparam logic [2:0] ACT_ADD_REF  = 3'd1;
   localparam logic [2:0] ACT_FREE     = 3'd2;
   localparam logic [2:0] ACT_REALLOC  = 3'd3;
   localparam logic [2:0] ACT_CONTAINS = 3'd4;

   // Control word driven to each slot cell
   typedef struct packed {
      logic launch;   // restart the free-slot search
      logic first;    // this cell takes the token on launch
      logic set;      // mark the slot in use
      logic clr;      // mark the slot free
   } slot_ctl_type;

endpackage

[sv/rcfb_slot_cell.sv]
// One slot cell: holds the in-use bit of a slot and passes the search token on.
module rcfb_slot_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rcfb_pkg::slot_ctl_type ctl,
   input  logic                  pass_in,
   output logic                  pass_out,
   output logic                  hit,
   output logic                  tok
);
   import rcfb_pkg::*;

   logic use_ff, use_in;
   logic tok_ff, tok_in;

   // Update the in-use bit
   always_comb begin
      use_in = use_ff;
      if (ctl.set) begin
         use_in = 1'b1;
      end else if (ctl.clr) begin
         use_in = 1'b0;
      end
   end

   // Hold the token on a free slot, hand it on past a used one
   assign tok_in   = ctl.launch ? ctl.first : ((tok_ff & ~use_ff) | pass_in);
   assign pass_out = tok_ff & use_ff;
   assign hit      = tok_ff & ~use_ff;
   assign tok      = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= 1'b0;
         tok_ff <= 1'b0;
      end else begin
         use_ff <= use_in;
         tok_ff <= tok_in;
      end
   end

endmodule

[sv/rcfb_align.sv]
// Two-stage round-up of a byte count to the alignment, by reciprocal multiply.
module rcfb_align #(
   parameter int ALIGN_BYTES = 4
) (
   input  logic        clock,
   input  logic [16:0] value,
   output logic [17:0] rounded
);
   import rcfb_pkg::*;

   localparam int          KS    = 17;
   localparam logic [17:0] RECIP = 18'((1 << KS) / ALIGN_BYTES);
   localparam logic [16:0] AL17  = 17'(ALIGN_BYTES);

   logic [34:0] prod;
   logic [16:0] quot_ff, quot_in;
   logic [16:0] val_ff;
   logic [16:0] base, rem, remc;
   logic [17:0] rounded_ff, rounded_in;

   // Estimate the quotient, low by at most one
   assign prod    = 35'(value) * 35'(RECIP);
   assign quot_in = prod[33:17];

   // Fix the remainder and round up
   always_comb begin
      base = 17'(quot_ff * AL17);
      rem  = val_ff - base;
      remc = (rem >= AL17) ? rem - AL17 : rem;
      if (remc != '0) begin
         rounded_in = {1'b0, val_ff} + {1'b0, AL17} - {1'b0, remc};
      end else begin
         rounded_in = {1'b0, val_ff};
      end
   end

   always_ff @(posedge clock) begin
      val_ff     <= value;
      quot_ff    <= quot_in;
      rounded_ff <= rounded_in;
   end

   assign rounded = rounded_ff;

endmodule

[sv/refcounted_first_fit_packet_buffer.sv]
// Steps, word taken to result registered: contains, unused codes, bad sizes and null go straight
// to the result; add ref walks the chain to its chunk, free adds a release; alloc rounds the size,
// then takes the empty head or walks the chain first-fit, places the chunk and waits for a free slot.
// Realloc first looks up its chunk and grows it in place when the room is there; a move adds a release.
// Throughput: one word at a time; the next word is taken the cycle after the result registers.
// Reset: synchronous; chain holds only the empty head chunk and every other slot is free.
module refcounted_first_fit_packet_buffer #(
   parameter int BUF_BYTES    = 8192,
   parameter int HEADER_BYTES = 8,
   parameter int ALIGN_BYTES  = 4,
   parameter int MAX_CHUNKS   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_size,
   input  logic [15:0] req_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [15:0] rsp_data_addr,
   output logic [15:0] rsp_copy_from,
   output logic [15:0] rsp_copy_len
);
   import rcfb_pkg::*;

   localparam int          SW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int          LW    = $clog2(MAX_CHUNKS + 1);
   localparam logic [LW-1:0] NIL = LW'(MAX_CHUNKS);
   localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);
   localparam logic [17:0] BUF18 = 18'(BUF_BYTES);

   typedef enum logic [16:0] {
      S_IDLE  = 17'b00000000000000001,
      S_W1    = 17'b00000000000000010,
      S_W2    = 17'b00000000000000100,
      S_LOC   = 17'b00000000000001000,
      S_LOCNX = 17'b00000000000010000,
      S_RDEC  = 17'b00000000000100000,
      S_PLC0  = 17'b00000000001000000,
      S_PLCH  = 17'b00000000010000000,
      S_PLC   = 17'b00000000100000000,
      S_NS0   = 17'b00000001000000000,
      S_NS1   = 17'b00000010000000000,
      S_NS2   = 17'b00000100000000000,
      S_SLOT  = 17'b00001000000000000,
      S_COM1  = 17'b00010000000000000,
      S_COM2  = 17'b00100000000000000,
      S_REL   = 17'b01000000000000000,
      S_DONE  = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;

   // Chunk tables
   logic [15:0]   start_mem [MAX_CHUNKS];
   logic [15:0]   bytes_mem [MAX_CHUNKS];
   logic [7:0]    refs_mem  [MAX_CHUNKS];
   logic [LW-1:0] link_mem  [MAX_CHUNKS];

   logic          start_we, bytes_we, refs_we, link_we;
   logic [SW-1:0] start_wa, bytes_wa, refs_wa, link_wa;
   logic [15:0]   start_wd, bytes_wd;
   logic [7:0]    refs_wd;
   logic [LW-1:0] link_wd;

   logic [SW-1:0] rd_addr, q_idx_ff;
   logic [15:0]   q_start_ff, q_bytes_ff;
   logic [7:0]    q_refs_ff;
   logic [LW-1:0] q_link_ff;

   // Head chunk fields kept in flops
   logic [15:0]   head_bytes_ff, head_bytes_in;
   logic [LW-1:0] head_link_ff, head_link_in;

   // Request and walk registers
   logic [2:0]    act_ff, act_in;
   logic [15:0]   size_ff, size_in, addr_ff, addr_in;
   logic [17:0]   need_ff, need_in;
   logic          found_ff, found_in;
   logic [SW-1:0] hit_ff, hit_in, pred_ff, pred_in, prev_ff, prev_in;
   logic [15:0]   hit_start_ff, hit_start_in, hit_bytes_ff, hit_bytes_in;
   logic [LW-1:0] hit_link_ff, hit_link_in;
   logic [7:0]    hit_refs_ff, hit_refs_in;
   logic [15:0]   nxs_ff, nxs_in;
   logic [SW-1:0] n_idx_ff, n_idx_in;
   logic [15:0]   n_start_ff, n_start_in, n_bytes_ff, n_bytes_in;
   logic [LW-1:0] n_link_ff, n_link_in;
   logic [17:0]   ns_ff, ns_in;
   logic [SW-1:0] slot_ff, slot_in;

   // Result and output registers
   logic          res_ok_ff, res_ok_in;
   logic [15:0]   res_data_ff, res_data_in, res_from_ff, res_from_in, res_len_ff, res_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [15:0]   rsp_data_ff, rsp_data_in, rsp_from_ff, rsp_from_in, rsp_len_ff, rsp_len_in;

   // Free-slot search
   logic          launch, set_en, clr_en;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [MAX_CHUNKS-1:0] pass_v, hit_v, tok_v;
   logic          hit_any, tok_any, srch_done;

   // Round-up unit
   logic [16:0]   align_x;
   logic [17:0]   align_out;

   // Datapath views
   logic          q_head;
   logic [15:0]   cur_start, cur_bytes;
   logic [LW-1:0] cur_link;
   logic          cur_nil;
   logic [17:0]   size18, addr18, cur_start18, d18, end18, gap18, ns18, ns_data18;
   logic          loc_hit, plc_brk, plch_fit, ns_fit, inplace, req_good;
   logic [15:0]   copy_len;

   // Read the chunk tables, registered
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[start_wa] <= start_wd;
      end
      q_start_ff <= start_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (bytes_we) begin
         bytes_mem[bytes_wa] <= bytes_wd;
      end
      q_bytes_ff <= bytes_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (refs_we) begin
         refs_mem[refs_wa] <= refs_wd;
      end
      q_refs_ff <= refs_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      q_link_ff <= link_mem[rd_addr];
      q_idx_ff  <= rd_addr;
   end

   // Overlay the head chunk on the table read
   assign q_head    = (q_idx_ff == '0);
   assign cur_start = q_head ? 16'd0 : q_start_ff;
   assign cur_bytes = q_head ? head_bytes_ff : q_bytes_ff;
   assign cur_link  = q_head ? head_link_ff : q_link_ff;
   assign cur_nil   = (cur_link == NIL);

   // Compare and fit arithmetic
   always_comb begin
      size18      = {2'b00, size_ff};
      addr18      = {2'b00, addr_ff};
      cur_start18 = {2'b00, cur_start};
      d18         = cur_start18 + HDR18;
      loc_hit     = (addr18 >= d18) && (addr18 < d18 + {2'b00, cur_bytes});
      end18       = {2'b00, n_start_ff} + HDR18 + {2'b00, n_bytes_ff};
      if ((cur_start18 >= end18) && (end18 != '0)) begin
         gap18 = cur_start18 - end18 + 18'd1;
      end else begin
         gap18 = '0;
      end
      plc_brk   = (gap18 >= need_ff);
      plch_fit  = (cur_start18 >= HDR18 + size18);
      ns18      = {2'b00, n_start_ff} + align_out;
      ns_fit    = (ns18 + HDR18 + size18) <= BUF18;
      ns_data18 = ns_ff + HDR18;
      if (hit_bytes_ff >= size_ff) begin
         inplace = 1'b1;
      end else if (hit_link_ff == NIL) begin
         inplace = ({2'b00, hit_start_ff} + HDR18 + size18) < BUF18;
      end else begin
         inplace = (nxs_ff >= hit_start_ff) &&
                   ({2'b00, nxs_ff} - {2'b00, hit_start_ff} >= HDR18 + size18);
      end
      copy_len = (hit_bytes_ff < size_ff) ? hit_bytes_ff : size_ff;
      req_good = (req_size != '0) && ({2'b00, req_size} <= BUF18);
   end

   // Feed the round-up unit
   assign align_x = state_ff == S_NS0 ? 17'(HEADER_BYTES) + {1'b0, n_bytes_ff}
                                      : 17'(HEADER_BYTES) + {1'b0, req_size};

   rcfb_align #(
      .ALIGN_BYTES(ALIGN_BYTES)
   ) u_align (
      .clock  (clock),
      .value  (align_x),
      .rounded(align_out)
   );

   // Row of slot cells; slot 0 is the head and is always in use
   assign pass_v[0] = 1'b0;
   assign hit_v[0]  = 1'b0;
   assign tok_v[0]  = 1'b0;

   for (genvar i = 1; i < MAX_CHUNKS; i++) begin : g_cell
      slot_ctl_type ctl;
      assign ctl.launch = launch;
      assign ctl.first  = (i == 1);
      assign ctl.set    = set_en && (slot_ff == SW'(i));
      assign ctl.clr    = clr_en && (hit_ff == SW'(i));
      rcfb_slot_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .pass_in (pass_v[i-1]),
         .pass_out(pass_v[i]),
         .hit     (hit_v[i]),
         .tok     (tok_v[i])
      );
   end

   assign hit_any   = |hit_v;
   assign tok_any   = |tok_v;
   assign srch_done = hit_any | ~tok_any;

   // Track the token position
   always_comb begin
      cnt_in = cnt_ff;
      if (launch) begin
         cnt_in = LW'(1);
      end else if (tok_any && !hit_any) begin
         cnt_in = cnt_ff + LW'(1);
      end
   end

   // Sequence the request
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      need_in      = need_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      pred_in      = pred_ff;
      prev_in      = prev_ff;
      hit_start_in = hit_start_ff;
      hit_bytes_in = hit_bytes_ff;
      hit_link_in  = hit_link_ff;
      hit_refs_in  = hit_refs_ff;
      nxs_in       = nxs_ff;
      n_idx_in     = n_idx_ff;
      n_start_in   = n_start_ff;
      n_bytes_in   = n_bytes_ff;
      n_link_in    = n_link_ff;
      ns_in        = ns_ff;
      slot_in      = slot_ff;
      res_ok_in    = res_ok_ff;
      res_data_in  = res_data_ff;
      res_from_in  = res_from_ff;
      res_len_in   = res_len_ff;
      head_bytes_in = head_bytes_ff;
      head_link_in  = head_link_ff;
      rd_addr      = q_idx_ff;
      launch       = 1'b0;
      set_en       = 1'b0;
      clr_en       = 1'b0;
      start_we     = 1'b0;
      start_wa     = slot_ff;
      start_wd     = ns_ff[15:0];
      bytes_we     = 1'b0;
      bytes_wa     = slot_ff;
      bytes_wd     = size_ff;
      refs_we      = 1'b0;
      refs_wa      = slot_ff;
      refs_wd      = 8'd1;
      link_we      = 1'b0;
      link_wa      = slot_ff;
      link_wd      = n_link_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_from_in  = rsp_from_ff;
      rsp_len_in   = rsp_len_ff;

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_valid) begin
               act_in      = req_action;
               size_in     = req_size;
               addr_in     = req_addr;
               found_in    = 1'b0;
               prev_in     = '0;
               res_ok_in   = 1'b0;
               res_data_in = '0;
               res_from_in = '0;
               res_len_in  = '0;
               launch      = 1'b1;
               case (req_action)
                  ACT_ALLOC, ACT_REALLOC: begin
                     state_in = req_good ? S_W1 : S_DONE;
                  end
                  ACT_ADD_REF, ACT_FREE: begin
                     state_in = (req_addr != '0) ? S_LOC : S_DONE;
                  end
                  ACT_CONTAINS: begin
                     res_ok_in = (req_addr != '0) && ({2'b00, req_addr} <= BUF18 - 18'd1);
                     state_in  = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_W1: begin
            state_in = S_W2;
         end

         // Capture the aligned chunk need and start the walk
         S_W2: begin
            need_in = align_out;
            rd_addr = '0;
            if (act_ff == ACT_REALLOC && addr_ff != '0) begin
               state_in = S_LOC;
            end else begin
               state_in = S_PLC0;
            end
         end

         // Walk the chain for the chunk that holds the address
         S_LOC: begin
            if (loc_hit) begin
               found_in     = 1'b1;
               hit_in       = q_idx_ff;
               pred_in      = prev_ff;
               hit_start_in = cur_start;
               hit_bytes_in = cur_bytes;
               hit_link_in  = cur_link;
               hit_refs_in  = q_refs_ff;
               case (act_ff)
                  ACT_ADD_REF: begin
                     refs_we   = 1'b1;
                     refs_wa   = q_idx_ff;
                     refs_wd   = q_refs_ff + 8'd1;
                     res_ok_in = 1'b1;
                     state_in  = S_DONE;
                  end
                  ACT_FREE: begin
                     res_ok_in = 1'b1;
                     state_in  = S_REL;
                  end
                  default: begin
                     if (cur_nil) begin
                        state_in = S_RDEC;
                     end else begin
                        rd_addr  = cur_link[SW-1:0];
                        state_in = S_LOCNX;
                     end
                  end
               endcase
            end else if (cur_nil) begin
               state_in = (act_ff == ACT_REALLOC) ? S_PLC0 : S_DONE;
            end else begin
               prev_in = q_idx_ff;
               rd_addr = cur_link[SW-1:0];
            end
         end

         S_LOCNX: begin
            nxs_in   = cur_start;
            state_in = S_RDEC;
         end

         // Grow in place when the room is there
         S_RDEC: begin
            if (inplace) begin
               if (hit_ff == '0) begin
                  head_bytes_in = size_ff;
               end else begin
                  bytes_we = 1'b1;
                  bytes_wa = hit_ff;
               end
               res_ok_in   = 1'b1;
               res_data_in = addr_ff;
               state_in    = S_DONE;
            end else begin
               state_in = S_PLC0;
            end
         end

         // Try the empty head first, else start the walk behind the head
         S_PLC0: begin
            if (head_bytes_ff == '0) begin
               if (head_link_ff == NIL) begin
                  head_bytes_in = size_ff;
                  refs_we       = 1'b1;
                  refs_wa       = '0;
                  res_ok_in     = 1'b1;
                  res_data_in   = 16'(HEADER_BYTES);
                  if (act_ff == ACT_REALLOC && found_ff) begin
                     res_from_in = addr_ff;
                     res_len_in  = copy_len;
                     state_in    = S_REL;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  rd_addr  = head_link_ff[SW-1:0];
                  state_in = S_PLCH;
               end
            end else begin
               n_idx_in   = '0;
               n_start_in = '0;
               n_bytes_in = head_bytes_ff;
               n_link_in  = head_link_ff;
               if (head_link_ff == NIL) begin
                  state_in = S_NS0;
               end else begin
                  rd_addr  = head_link_ff[SW-1:0];
                  state_in = S_PLC;
               end
            end
         end

         S_PLCH: begin
            if (plch_fit) begin
               head_bytes_in = size_ff;
               refs_we       = 1'b1;
               refs_wa       = '0;
               res_ok_in     = 1'b1;
               res_data_in   = 16'(HEADER_BYTES);
               if (act_ff == ACT_REALLOC && found_ff) begin
                  res_from_in = addr_ff;
                  res_len_in  = copy_len;
                  state_in    = S_REL;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               n_idx_in   = q_idx_ff;
               n_start_in = cur_start;
               n_bytes_in = cur_bytes;
               n_link_in  = cur_link;
               if (cur_nil) begin
                  state_in = S_NS0;
               end else begin
                  rd_addr  = cur_link[SW-1:0];
                  state_in = S_PLC;
               end
            end
         end

         // First-fit walk: stop at the first gap that holds the chunk
         S_PLC: begin
            if (plc_brk) begin
               state_in = S_NS0;
            end else begin
               n_idx_in   = q_idx_ff;
               n_start_in = cur_start;
               n_bytes_in = cur_bytes;
               n_link_in  = cur_link;
               if (cur_nil) begin
                  state_in = S_NS0;
               end else begin
                  rd_addr = cur_link[SW-1:0];
               end
            end
         end

         S_NS0: begin
            state_in = S_NS1;
         end

         S_NS1: begin
            state_in = S_NS2;
         end

         // Check the new chunk against the buffer end
         S_NS2: begin
            if (ns_fit) begin
               ns_in    = ns18;
               state_in = S_SLOT;
            end else begin
               state_in = S_DONE;
            end
         end

         // Wait for the free-slot token
         S_SLOT: begin
            if (srch_done) begin
               if (hit_any) begin
                  slot_in  = cnt_ff[SW-1:0];
                  state_in = S_COM1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Fill the new slot
         S_COM1: begin
            start_we = 1'b1;
            bytes_we = 1'b1;
            refs_we  = 1'b1;
            link_we  = 1'b1;
            set_en   = 1'b1;
            if (n_idx_ff == '0) begin
               head_link_in = LW'(slot_ff);
            end
            state_in = S_COM2;
         end

         // Link it behind its predecessor
         S_COM2: begin
            if (n_idx_ff != '0) begin
               link_we = 1'b1;
               link_wa = n_idx_ff;
               link_wd = LW'(slot_ff);
            end
            res_ok_in   = 1'b1;
            res_data_in = ns_data18[15:0];
            if (act_ff == ACT_REALLOC && found_ff) begin
               res_from_in = addr_ff;
               res_len_in  = copy_len;
               if (n_idx_ff == pred_ff) begin
                  pred_in = slot_ff;
               end
               if (n_idx_ff == hit_ff) begin
                  hit_link_in = LW'(slot_ff);
               end
               state_in = S_REL;
            end else begin
               state_in = S_DONE;
            end
         end

         // Drop a reference; unlink at zero
         S_REL: begin
            refs_we = 1'b1;
            refs_wa = hit_ff;
            refs_wd = hit_refs_ff - 8'd1;
            if (hit_refs_ff == 8'd1) begin
               if (hit_ff == '0) begin
                  head_bytes_in = '0;
               end else begin
                  clr_en = 1'b1;
                  if (pred_ff == '0) begin
                     head_link_in = hit_link_ff;
                  end else begin
                     link_we = 1'b1;
                     link_wa = pred_ff;
                     link_wd = hit_link_ff;
                  end
               end
            end
            state_in = S_DONE;
         end

         // Hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_data_in  = res_data_ff;
               rsp_from_in  = res_from_ff;
               rsp_len_in   = res_len_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_bytes_ff <= '0;
         head_link_ff  <= NIL;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_bytes_ff <= head_bytes_in;
         head_link_ff  <= head_link_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      need_ff      <= need_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      pred_ff      <= pred_in;
      prev_ff      <= prev_in;
      hit_start_ff <= hit_start_in;
      hit_bytes_ff <= hit_bytes_in;
      hit_link_ff  <= hit_link_in;
      hit_refs_ff  <= hit_refs_in;
      nxs_ff       <= nxs_in;
      n_idx_ff     <= n_idx_in;
      n_start_ff   <= n_start_in;
      n_bytes_ff   <= n_bytes_in;
      n_link_ff    <= n_link_in;
      ns_ff        <= ns_in;
      slot_ff      <= slot_in;
      res_ok_ff    <= res_ok_in;
      res_data_ff  <= res_data_in;
      res_from_ff  <= res_from_in;
      res_len_ff   <= res_len_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_from_ff  <= rsp_from_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_data_addr = rsp_data_ff;
   assign rsp_copy_from = rsp_from_ff;
   assign rsp_copy_len  = rsp_len_ff;

endmodule
